// ===== sv/phpv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// phpv_pkg
// Shared types, constants and control store for the piezo hit peak block.
// ----------------------------------------------------------------------------
package phpv_pkg;

	localparam int unsigned VEL_MIN  = 35;
	localparam int unsigned VEL_MAX  = 127;
	localparam int unsigned MV_FULL  = 3300;
	localparam int unsigned ADC_FULL = 65535;

	// per-mode threshold and full-scale in mV, unused codes act as fallback
	localparam logic [11:0] THR_MV [8] = '{
		12'd1000, 12'd150, 12'd90, 12'd90, 12'd150, 12'd120, 12'd150, 12'd150
	};
	localparam logic [11:0] FULL_MV [8] = '{
		12'd2000, 12'd1500, 12'd2000, 12'd2200, 12'd1900, 12'd1800, 12'd1900, 12'd1900
	};

	localparam logic [2:0] MODE_RESET = 3'd5;

	typedef enum logic [3:0] {
		ST_WAIT     = 4'd0,
		ST_TRACK    = 4'd1,
		ST_TEST_REJ = 4'd2,
		ST_TEST_END = 4'd3,
		ST_MV_MUL   = 4'd4,
		ST_MV_FIX   = 4'd5,
		ST_V_MUL    = 4'd6,
		ST_V_ADD    = 4'd7,
		ST_EMIT_HIT = 4'd8,
		ST_EMIT_REJ = 4'd9
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_TAKE,
		OP_TRACK,
		OP_MV_MUL,
		OP_MV_FIX,
		OP_V_MUL,
		OP_V_ADD,
		OP_EMIT_HIT,
		OP_EMIT_REJ
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ACCEPT,
		COND_REJECT,
		COND_DONE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump;
		step_t next;
	} uword_t;

	// control store: jump when the condition holds, else go to next
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_WAIT:     w = '{OP_TAKE,     COND_ACCEPT,   ST_TRACK,    ST_WAIT};
			ST_TRACK:    w = '{OP_TRACK,    COND_NONE,     ST_WAIT,     ST_TEST_REJ};
			ST_TEST_REJ: w = '{OP_NOP,      COND_REJECT,   ST_EMIT_REJ, ST_TEST_END};
			ST_TEST_END: w = '{OP_NOP,      COND_DONE,     ST_MV_MUL,   ST_WAIT};
			ST_MV_MUL:   w = '{OP_MV_MUL,   COND_NONE,     ST_WAIT,     ST_MV_FIX};
			ST_MV_FIX:   w = '{OP_MV_FIX,   COND_NONE,     ST_WAIT,     ST_V_MUL};
			ST_V_MUL:    w = '{OP_V_MUL,    COND_NONE,     ST_WAIT,     ST_V_ADD};
			ST_V_ADD:    w = '{OP_V_ADD,    COND_NONE,     ST_WAIT,     ST_EMIT_HIT};
			ST_EMIT_HIT: w = '{OP_EMIT_HIT, COND_OUT_BUSY, ST_EMIT_HIT, ST_WAIT};
			ST_EMIT_REJ: w = '{OP_EMIT_REJ, COND_OUT_BUSY, ST_EMIT_REJ, ST_WAIT};
			default:     w = '{OP_NOP,      COND_NONE,     ST_WAIT,     ST_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== sv/piezo_hit_peak_velocity.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// piezo_hit_peak_velocity
// Captures the peak of a piezo hit over a tick window and maps it to a
// note velocity; spurious hits are rejected early.
// ----------------------------------------------------------------------------
// One input word per sample tick (in_valid/in_stall): ADC sample, comparator
// level and falling-edge flag. An edge while idle opens a capture window;
// the tick that opens it takes no sample. Ticks in the window track the peak.
// At tick REJECT_TICK a high comparator drops the hit and a rejected word
// (status 1, zeros) is sent. At tick WINDOW_TICKS the peak is converted to mV
// and mapped to a velocity clamped to 35..127.
// Output words leave through out_valid/out_stall from a holding register.
// A microcoded sequencer runs each tick: an ordinary tick passes through
// take, track and two test steps; a rejected hit goes from the reject test
// to an emit step, and a finished hit adds two multiply steps, one
// correction, one add and one emit after the tests. The emit step waits while
// the holding register is full and stalled. The next tick is taken once the
// sequencer is back at its wait step, even while an earlier word still waits
// in the holding register.
// Reset clears the window state and the output valid flag, and restores the
// power-on sensitivity mode 5. cfg_write_en writes the mode.
// ----------------------------------------------------------------------------
module piezo_hit_peak_velocity #(
	parameter int FRAC_BITS    = 16,
	parameter int REJECT_TICK  = 4,
	parameter int WINDOW_TICKS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [2:0]  cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] adc_sample,
	input  wire logic        comparator_high,
	input  wire logic        hit_edge,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit_status,
	output logic [6:0]       velocity,
	output logic [11:0]      peak_millivolts
);

	localparam int SW = FRAC_BITS - 2;   // slope width
	localparam int PW = 12 + SW;         // mv * slope
	localparam int VW = FRAC_BITS + 12;  // signed velocity accumulator

	localparam longint ONE  = longint'(1) << FRAC_BITS;
	localparam longint HALF = longint'(1) << (FRAC_BITS - 1);
	localparam longint SPAN = longint'(phpv_pkg::VEL_MAX - phpv_pkg::VEL_MIN);
	localparam longint VMIN = longint'(phpv_pkg::VEL_MIN);

	localparam longint SLOPE [8] = '{
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[0] - phpv_pkg::THR_MV[0]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[1] - phpv_pkg::THR_MV[1]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[2] - phpv_pkg::THR_MV[2]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[3] - phpv_pkg::THR_MV[3]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[4] - phpv_pkg::THR_MV[4]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[5] - phpv_pkg::THR_MV[5]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[6] - phpv_pkg::THR_MV[6]),
		SPAN * ONE / longint'(phpv_pkg::FULL_MV[7] - phpv_pkg::THR_MV[7])
	};

	// intercept with the rounding half folded in
	localparam longint BIAS [8] = '{
		VMIN * ONE - longint'(phpv_pkg::THR_MV[0]) * SLOPE[0] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[1]) * SLOPE[1] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[2]) * SLOPE[2] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[3]) * SLOPE[3] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[4]) * SLOPE[4] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[5]) * SLOPE[5] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[6]) * SLOPE[6] + HALF,
		VMIN * ONE - longint'(phpv_pkg::THR_MV[7]) * SLOPE[7] + HALF
	};

	localparam logic [4:0] REJ_T = 5'(REJECT_TICK);
	localparam logic [4:0] WIN_T = 5'(WINDOW_TICKS);

	// control state
	phpv_pkg::step_t step_q;
	logic [2:0]      mode_q;
	logic            capturing_q;
	logic [4:0]      tick_q;
	logic            reject_q;
	logic            done_q;
	logic            out_valid_q;

	// datapath
	logic [15:0]          sample_q;
	logic                 comp_q;
	logic                 edge_q;
	logic [15:0]          peak_q;
	logic [27:0]          prod_q;
	logic [11:0]          mv_q;
	logic [PW-1:0]        vprod_q;
	logic signed [VW-1:0] v_q;
	logic                 status_q;
	logic [6:0]           vel_q;
	logic [11:0]          pmv_q;

	phpv_pkg::uword_t uw;
	logic             cond_hit;
	logic             out_busy;
	logic             accept;
	logic             emit_step;
	logic [4:0]       tick_nxt;
	logic [11:0]      mv_q0;
	logic [16:0]      mv_rem;
	logic [11:0]      mv_fixed;
	logic [SW-1:0]    slope_w;
	logic signed [VW-1:0] bias_w;
	logic [11:0]      v_int;
	logic [6:0]       vel_clamped;

	assign uw        = phpv_pkg::ucode(step_q);
	assign out_busy  = out_valid_q && out_stall;
	assign in_stall  = (uw.op != phpv_pkg::OP_TAKE);
	assign accept    = in_valid && !in_stall;
	assign emit_step = (uw.op == phpv_pkg::OP_EMIT_HIT) || (uw.op == phpv_pkg::OP_EMIT_REJ);
	assign tick_nxt  = tick_q + 5'd1;

	always_comb begin
		case (uw.cond)
			phpv_pkg::COND_NONE:     cond_hit = 1'b0;
			phpv_pkg::COND_ACCEPT:   cond_hit = accept;
			phpv_pkg::COND_REJECT:   cond_hit = reject_q;
			phpv_pkg::COND_DONE:     cond_hit = done_q;
			phpv_pkg::COND_OUT_BUSY: cond_hit = out_busy;
			default:                 cond_hit = 1'b0;
		endcase
	end

	// floor(x / 65535): one correction step after the shift
	assign mv_q0    = prod_q[27:16];
	assign mv_rem   = {1'b0, prod_q[15:0]} + 17'(mv_q0);
	assign mv_fixed = (mv_rem >= 17'(phpv_pkg::ADC_FULL)) ? mv_q0 + 12'd1 : mv_q0;

	assign slope_w = SW'(SLOPE[mode_q]);
	assign bias_w  = VW'(BIAS[mode_q]);

	assign v_int = v_q[VW-1:FRAC_BITS];
	always_comb begin
		if (v_q < 0)
			vel_clamped = 7'(phpv_pkg::VEL_MIN);
		else if (v_int > 12'(phpv_pkg::VEL_MAX))
			vel_clamped = 7'(phpv_pkg::VEL_MAX);
		else if (v_int < 12'(phpv_pkg::VEL_MIN))
			vel_clamped = 7'(phpv_pkg::VEL_MIN);
		else
			vel_clamped = v_int[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= phpv_pkg::ST_WAIT;
			mode_q      <= phpv_pkg::MODE_RESET;
			capturing_q <= 1'b0;
			tick_q      <= 5'd0;
			reject_q    <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= cond_hit ? uw.jump : uw.next;
			if (cfg_write_en)
				mode_q <= cfg_write_data;
			if (emit_step && !out_busy)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (uw.op)
				phpv_pkg::OP_TRACK: begin
					reject_q <= 1'b0;
					done_q   <= 1'b0;
					if (!capturing_q) begin
						if (edge_q) begin
							capturing_q <= 1'b1;
							tick_q      <= 5'd0;
						end
					end else if (tick_nxt == REJ_T && comp_q) begin
						reject_q    <= 1'b1;
						capturing_q <= 1'b0;
						tick_q      <= 5'd0;
					end else if (tick_nxt == WIN_T) begin
						done_q      <= 1'b1;
						capturing_q <= 1'b0;
						tick_q      <= 5'd0;
					end else begin
						tick_q <= tick_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (uw.op)
			phpv_pkg::OP_TAKE: begin
				if (accept) begin
					sample_q <= adc_sample;
					comp_q   <= comparator_high;
					edge_q   <= hit_edge;
				end
			end
			phpv_pkg::OP_TRACK: begin
				if (!capturing_q) begin
					if (edge_q)
						peak_q <= 16'd0;
				end else if (sample_q > peak_q) begin
					peak_q <= sample_q;
				end
			end
			phpv_pkg::OP_MV_MUL: prod_q  <= 28'(peak_q) * 28'(phpv_pkg::MV_FULL);
			phpv_pkg::OP_MV_FIX: mv_q    <= mv_fixed;
			phpv_pkg::OP_V_MUL:  vprod_q <= PW'(mv_q) * PW'(slope_w);
			phpv_pkg::OP_V_ADD:  v_q     <= VW'($signed({1'b0, vprod_q})) + bias_w;
			phpv_pkg::OP_EMIT_HIT: begin
				if (!out_busy) begin
					status_q <= 1'b0;
					vel_q    <= vel_clamped;
					pmv_q    <= mv_q;
				end
			end
			phpv_pkg::OP_EMIT_REJ: begin
				if (!out_busy) begin
					status_q <= 1'b1;
					vel_q    <= 7'd0;
					pmv_q    <= 12'd0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign hit_status      = status_q;
	assign velocity        = vel_q;
	assign peak_millivolts = pmv_q;

endmodule
`default_nettype wire

// ===== sv/phpv_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// phpv_checker
// Port-level checks on the piezo hit peak block, bound to the top level.
// ----------------------------------------------------------------------------
module phpv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        hit_status,
	input wire logic [6:0]  velocity,
	input wire logic [11:0] peak_millivolts
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_status)
			&& $stable(velocity) && $stable(peak_millivolts))
		else $error("stalled output word changed");

	// rejected hits carry zeros
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_status |-> velocity == 7'd0 && peak_millivolts == 12'd0)
		else $error("rejected word not zero");

	// finished hits stay in range
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit_status |-> velocity >= 7'd35 && velocity <= 7'd127
			&& peak_millivolts <= 12'd3300)
		else $error("finished word out of range");

	// a new word is issued only while the input side is held off
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word issued while taking input");

	// a taken word is followed by a busy cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on consecutive cycles");

endmodule

bind piezo_hit_peak_velocity phpv_checker u_phpv_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.hit_status      (hit_status),
	.velocity        (velocity),
	.peak_millivolts (peak_millivolts)
);
`default_nettype wire
